// ===== rtl/prle_pkg.sv =====
// Package: shared types and constants of the palette run-length encoder.
`timescale 1ns / 1ps

package prle_pkg;

  localparam int unsigned PaletteDepthDef = 128;
  localparam int unsigned QueueDepthDef   = 2;

  localparam logic [8:0]  MaxRun         = 9'h17f;
  localparam logic [8:0]  RunLongMin     = 9'h100;
  localparam logic [8:0]  RunMidMin      = 9'h080;
  localparam logic [8:0]  RunSingle      = 9'h001;
  localparam logic [7:0]  CodeLong       = 8'h82;
  localparam logic [7:0]  CodeMid        = 8'h81;
  localparam logic [7:0]  CodeShort      = 8'h80;
  localparam logic [6:0]  RunLowMask     = 7'h7f;
  localparam logic [15:0] LenMax         = 16'hffff;
  localparam logic [15:0] SizeLimitReset = 16'd8192;

  // One closed run handed from the front to the back.
  typedef struct packed {
    logic [31:0] color;
    logic [8:0]  count;
    logic        final_run;
  } run_rec_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_EMIT
  } back_state_e;

endpackage

// ===== rtl/prle_front.sv =====
// Front end: accepts pixels, tracks the open run and queues closed runs.
`timescale 1ns / 1ps

module prle_front
  import prle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_i,
  input  logic        end_of_image_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output run_rec_t    q_rec_o
);

  logic [31:0] run_color_q, run_color_d;
  logic [8:0]  run_count_q, run_count_d;
  logic        pend_q, pend_d;
  run_rec_t    pend_rec_q, pend_rec_d;

  logic accept;
  logic close_run;

  // A held flush record or a full queue blocks the next pixel.
  assign in_stall_o = pend_q | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign close_run  = (run_count_q != '0) &&
                      ((pixel_i != run_color_q) || (run_count_q >= MaxRun));

  always_comb begin
    run_color_d = run_color_q;
    run_count_d = run_count_q;
    pend_d      = pend_q;
    pend_rec_d  = pend_rec_q;
    q_push_o    = 1'b0;
    q_rec_o     = pend_rec_q;

    if (pend_q) begin
      if (!q_full_i) begin
        q_push_o = 1'b1;
        pend_d   = 1'b0;
      end
    end else if (accept) begin
      if (close_run || run_count_q == '0) begin
        run_color_d = pixel_i;
        run_count_d = RunSingle;
      end else begin
        run_count_d = run_count_q + 9'd1;
      end

      if (close_run) begin
        q_push_o = 1'b1;
        q_rec_o  = '{color: run_color_q, count: run_count_q, final_run: 1'b0};
      end

      if (end_of_image_i) begin
        // flush the run that holds this pixel
        pend_rec_d = '{color: run_color_d, count: run_count_d, final_run: 1'b1};
        if (close_run) begin
          pend_d = 1'b1;
        end else begin
          q_push_o = 1'b1;
          q_rec_o  = pend_rec_d;
        end
        run_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_color_q <= '0;
      run_count_q <= '0;
      pend_q      <= 1'b0;
    end else begin
      run_color_q <= run_color_d;
      run_count_q <= run_count_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_rec_q <= pend_rec_d;
  end

endmodule

// ===== rtl/prle_fifo.sv =====
// Short queue of closed runs between front and back.
`timescale 1ns / 1ps

module prle_fifo
  import prle_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  run_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output run_rec_t pop_rec_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

  run_rec_t        slots_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_rec_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

// ===== rtl/prle_back.sv =====
// Back end: palette search and insert, code byte generation, output register.
`timescale 1ns / 1ps

module prle_back
  import prle_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  run_rec_t    q_rec_i,
  output logic        q_pop_o,
  input  logic [15:0] size_limit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        final_byte_o,
  output logic        new_entry_o,
  output logic [31:0] entry_color_o,
  output logic        palette_full_o,
  output logic [7:0]  color_count_o,
  output logic [15:0] coded_length_o,
  output logic        too_large_o
);

  localparam int unsigned IW = $clog2(PALETTE_DEPTH);
  localparam int unsigned UW = $clog2(PALETTE_DEPTH + 1);

  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] rdata_q;

  back_state_e state_q, state_d;
  run_rec_t    run_q, run_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [UW-1:0] used_q, used_d;
  logic [15:0]   bytes_q, bytes_d;
  logic          is_new_q, is_new_d;
  logic          full_q, full_d;
  logic [1:0]    bpos_q, bpos_d;

  logic          mem_we;
  logic          mem_re;

  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d;
  logic          of_q, of_d;
  logic          on_q, on_d;
  logic [31:0]   oc_q, oc_d;
  logic          opf_q, opf_d;
  logic [7:0]    occ_q, occ_d;
  logic [15:0]   olen_q, olen_d;
  logic          otl_q, otl_d;

  logic [1:0]    nbytes;
  logic [7:0]    hdr_byte;
  logic          last_byte;
  logic          slot_free;
  logic [15:0]   bytes_inc;
  logic [17:0]   total_size;

  always_comb begin
    if (run_q.count >= RunMidMin) begin
      nbytes = 2'd3;
    end else if (run_q.count > RunSingle) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd1;
    end
  end

  always_comb begin
    if (nbytes == 2'd3) begin
      if (bpos_q == 2'd0) begin
        hdr_byte = (run_q.count >= RunLongMin) ? CodeLong : CodeMid;
      end else if (run_q.count >= RunLongMin) begin
        hdr_byte = CodeShort | {1'b0, run_q.count[6:0] & RunLowMask};
      end else begin
        hdr_byte = run_q.count[7:0];
      end
    end else begin
      hdr_byte = CodeShort | {1'b0, run_q.count[6:0] & RunLowMask};
    end
  end

  assign last_byte  = (bpos_q == nbytes - 2'd1);
  assign slot_free  = ~ov_q | ~out_stall_i;
  assign bytes_inc  = (bytes_q != LenMax) ? bytes_q + 16'd1 : bytes_q;
  assign total_size = (18'(used_q) << 2) + 18'(bytes_inc);

  always_comb begin
    state_d  = state_q;
    run_d    = run_q;
    idx_d    = idx_q;
    used_d   = used_q;
    bytes_d  = bytes_q;
    is_new_d = is_new_q;
    full_d   = full_q;
    bpos_d   = bpos_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;

    ov_d  = ov_q & out_stall_i;
    ob_d  = ob_q;
    of_d  = of_q;
    on_d  = on_q;
    oc_d  = oc_q;
    opf_d = opf_q;
    occ_d = occ_q;
    olen_d = olen_q;
    otl_d = otl_q;

    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          run_d    = q_rec_i;
          idx_d    = '0;
          is_new_d = 1'b0;
          full_d   = 1'b0;
          bpos_d   = '0;
          if (used_q == '0) begin
            // empty palette: the colour is always a miss
            state_d = B_CMP;
          end else begin
            state_d = B_READ;
          end
        end
      end

      B_READ: begin
        mem_re  = 1'b1;
        state_d = B_CMP;
      end

      B_CMP: begin
        if (used_q != '0 && rdata_q == run_q.color) begin
          state_d = B_EMIT;
        end else if (used_q != '0 && UW'(idx_q) + UW'(1) != used_q) begin
          idx_d   = idx_q + IW'(1);
          state_d = B_READ;
        end else begin
          if (used_q < UW'(PALETTE_DEPTH)) begin
            mem_we   = 1'b1;
            idx_d    = used_q[IW-1:0];
            used_d   = used_q + UW'(1);
            is_new_d = 1'b1;
          end else begin
            idx_d  = '0;
            full_d = 1'b1;
          end
          state_d = B_EMIT;
        end
      end

      B_EMIT: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          occ_d  = 8'(used_q);
          olen_d = bytes_inc;
          bytes_d = bytes_inc;
          if (last_byte) begin
            ob_d  = 8'(idx_q);
            on_d  = is_new_q;
            oc_d  = is_new_q ? run_q.color : 32'd0;
            opf_d = full_q;
            of_d  = run_q.final_run;
            otl_d = run_q.final_run && (total_size > 18'(size_limit_i));
            state_d = B_IDLE;
            if (run_q.final_run) begin
              used_d  = '0;
              bytes_d = '0;
            end
          end else begin
            ob_d  = hdr_byte;
            on_d  = 1'b0;
            oc_d  = 32'd0;
            opf_d = 1'b0;
            of_d  = 1'b0;
            otl_d = 1'b0;
            bpos_d = bpos_q + 2'd1;
          end
        end
      end

      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      used_q  <= '0;
      bytes_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      bytes_q <= bytes_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q    <= run_d;
    idx_q    <= idx_d;
    is_new_q <= is_new_d;
    full_q   <= full_d;
    bpos_q   <= bpos_d;
    ob_q     <= ob_d;
    of_q     <= of_d;
    on_q     <= on_d;
    oc_q     <= oc_d;
    opf_q    <= opf_d;
    occ_q    <= occ_d;
    olen_q   <= olen_d;
    otl_q    <= otl_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pal_mem[used_q[IW-1:0]] <= run_q.color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= pal_mem[idx_q];
    end
  end

  assign out_valid_o    = ov_q;
  assign code_byte_o    = ob_q;
  assign final_byte_o   = of_q;
  assign new_entry_o    = on_q;
  assign entry_color_o  = oc_q;
  assign palette_full_o = opf_q;
  assign color_count_o  = occ_q;
  assign coded_length_o = olen_q;
  assign too_large_o    = otl_q;

endmodule

// ===== rtl/palette_rle_image_encoder_core.sv =====
// Top level: palette run-length image encoder core.
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the pixel channel is not stalled; the back end
//   takes the next closed run from the queue only after it has sent the last code byte
//   of the current run (1..3 bytes per run).
// Reset (rst_ni low, async): no run open, empty palette, zero byte count, queue empty,
//   size_limit back to 8192; palette contents are undefined until written.

module palette_rle_image_encoder_core
  import prle_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef,
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // size limit register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // pixel channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_i,
  input  logic        end_of_image_i,
  // code byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        final_byte_o,
  output logic        new_entry_o,
  output logic [31:0] entry_color_o,
  output logic        palette_full_o,
  output logic [7:0]  color_count_o,
  output logic [15:0] coded_length_o,
  output logic        too_large_o
);

  logic [15:0] size_limit_q;

  logic     q_push, q_pop, q_full, q_empty;
  run_rec_t q_push_rec, q_pop_rec;

  // The user must change the size limit only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_limit_q <= SizeLimitReset;
    end else if (cfg_we_i) begin
      size_limit_q <= cfg_wdata_i;
    end
  end

  // Front: run tracking; pushes up to two closed runs per pixel (mismatch + flush),
  // the second one held until the queue has room while the pixel channel stalls.
  prle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .end_of_image_i (end_of_image_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_rec_o        (q_push_rec)
  );

  prle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (q_push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_rec_o  (q_pop_rec)
  );

  // Back: sequential palette search, insert or full fallback, then 1..3 code byte
  // transfers through the output register; the final run clears palette and count.
  prle_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_rec_i        (q_pop_rec),
    .q_pop_o        (q_pop),
    .size_limit_i   (size_limit_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_byte_o    (code_byte_o),
    .final_byte_o   (final_byte_o),
    .new_entry_o    (new_entry_o),
    .entry_color_o  (entry_color_o),
    .palette_full_o (palette_full_o),
    .color_count_o  (color_count_o),
    .coded_length_o (coded_length_o),
    .too_large_o    (too_large_o)
  );

endmodule
